// ----- src/sled_pkg.sv -----
// Shared types, constants and the run-close function of the scanline edge and line detector.
package sled_pkg;

	localparam int PIX_W          = 8;
	localparam int THR_W          = 9;
	localparam int WID_W          = 10;
	localparam int POS_W          = 10;
	localparam int GRAD_W         = 11;
	localparam int SPAN_W         = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 10;
	localparam int OQ_DEPTH       = 3;
	localparam int OQ_CNT_W       = 2;
	localparam int ROW_PIXELS_DEF = 316;

	localparam logic [THR_W-1:0] GRAD_THR_RST = THR_W'(20);
	localparam logic [WID_W-1:0] MIN_EDGE_RST = WID_W'(0);
	localparam logic [WID_W-1:0] MAX_EDGE_RST = WID_W'(6);
	localparam logic [WID_W-1:0] MIN_LINE_RST = WID_W'(5);
	localparam logic [WID_W-1:0] MAX_LINE_RST = WID_W'(15);
	localparam logic [WID_W-1:0] RUN_LEN_MAX  = {WID_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAD_THR = 3'd0,
		CFG_MIN_EDGE = 3'd1,
		CFG_MAX_EDGE = 3'd2,
		CFG_MIN_LINE = 3'd3,
		CFG_MAX_LINE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] grad_threshold;
		logic [WID_W-1:0] min_edge_width;
		logic [WID_W-1:0] max_edge_width;
		logic [WID_W-1:0] min_line_width;
		logic [WID_W-1:0] max_line_width;
	} cfg_t;

	typedef struct packed {
		logic             line_found;
		logic [WID_W-1:0] line_center;
		logic [WID_W-1:0] line_width;
		logic             row_end;
	} result_t;

	typedef struct packed {
		logic [OQ_CNT_W-1:0] n;
		result_t             res0;
		result_t             res1;
	} push_t;

	typedef struct packed {
		result_t          res;
		logic             ok;
		logic [POS_W-1:0] start;
	} close_t;

	// Close a run: check its width, pair it with the prior edge, update the prior edge.
	function automatic close_t close_run(
		input logic [POS_W-1:0] start,
		input logic [WID_W-1:0] len,
		input logic             prior_ok,
		input logic [POS_W-1:0] prior_start,
		input cfg_t             cfg
	);
		close_t            c;
		logic              in_bounds;
		logic [SPAN_W-1:0] span;
		c         = '0;
		in_bounds = (len >= cfg.min_edge_width) && (len <= cfg.max_edge_width);
		span      = SPAN_W'(start) + SPAN_W'(len) - SPAN_W'(prior_start);
		if (in_bounds && prior_ok && (span >= SPAN_W'(cfg.min_line_width)) &&
				(span <= SPAN_W'(cfg.max_line_width))) begin
			c.res.line_found  = 1'b1;
			c.res.line_center = WID_W'(SPAN_W'(prior_start) + (span >> 1));
			c.res.line_width  = span[WID_W-1:0];
		end
		c.ok    = in_bounds;
		c.start = in_bounds ? start : prior_start;
		return c;
	endfunction

endpackage

// ----- src/sled_if.sv -----
// Handshake channel interfaces for pixel items and result items.
interface sled_in_if import sled_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             row_start;

	modport source (output valid, pixel, row_start, input ready);
	modport sink   (input valid, pixel, row_start, output ready);
endinterface

interface sled_out_if import sled_pkg::*;;
	logic             valid;
	logic             ready;
	logic             line_found;
	logic [WID_W-1:0] line_center;
	logic [WID_W-1:0] line_width;
	logic             row_end;

	modport source (output valid, line_found, line_center, line_width, row_end, input ready);
	modport sink   (input valid, line_found, line_center, line_width, row_end, output ready);
endinterface

// ----- src/sled_core.sv -----
// Gradient, edge-run tracking and line pairing for one pixel per cycle while accept is high.
module sled_core import sled_pkg::*; #(
	parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             accept,
	input  logic [PIX_W-1:0] pixel,
	input  logic             row_start,
	output push_t            push
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROW_PIXELS - 1);

	logic [PIX_W-1:0] hist_q [2];
	logic [POS_W-1:0] pos_q;
	logic             run_open_q;
	logic             run_pos_q;
	logic [POS_W-1:0] run_start_q;
	logic [WID_W-1:0] run_len_q;
	logic             prior_ok_q;
	logic [POS_W-1:0] prior_start_q;

	logic [POS_W-1:0] pos;
	logic             open0, rpos0, pok0;
	logic [POS_W-1:0] start0, pstart0;
	logic [WID_W-1:0] len0;

	logic signed [GRAD_W-1:0] grad, thr_s;
	logic             active, hit, sign_pos, close1, close2, last, f1, f2;
	logic [POS_W-1:0] idx;
	close_t           c1, c2;

	logic             open1, rpos1, pok1;
	logic [POS_W-1:0] start1, pstart1;
	logic [WID_W-1:0] len1;

	logic             pok2;
	logic [POS_W-1:0] pstart2;

	always_comb begin
		// a row start drops the unfinished row before this pixel is used
		pos     = row_start ? '0 : pos_q;
		open0   = row_start ? 1'b0 : run_open_q;
		rpos0   = row_start ? 1'b0 : run_pos_q;
		start0  = row_start ? '0 : run_start_q;
		len0    = row_start ? '0 : run_len_q;
		pok0    = row_start ? 1'b0 : prior_ok_q;
		pstart0 = row_start ? '0 : prior_start_q;

		grad     = $signed({2'b00, hist_q[1], 1'b0}) - $signed({2'b00, pixel, 1'b0});
		thr_s    = $signed({2'b00, cfg.grad_threshold});
		hit      = (grad > thr_s) || (grad < -thr_s);
		sign_pos = grad > $signed(GRAD_W'(0));
		active   = pos >= POS_W'(2);
		idx      = pos - POS_W'(2);
		last     = pos >= LAST_POS;

		close1 = active && open0 && (!hit || (sign_pos != rpos0));
		c1     = close_run(start0, len0, pok0, pstart0, cfg);

		open1   = open0;
		rpos1   = rpos0;
		start1  = start0;
		len1    = len0;
		pok1    = close1 ? c1.ok : pok0;
		pstart1 = close1 ? c1.start : pstart0;
		if (active && hit) begin
			if (open0 && !close1) begin
				len1 = (len0 == RUN_LEN_MAX) ? len0 : len0 + WID_W'(1);
			end else begin
				open1  = 1'b1;
				rpos1  = sign_pos;
				start1 = idx;
				len1   = WID_W'(1);
			end
		end else if (close1) begin
			open1 = 1'b0;
			len1  = '0;
		end

		close2  = last && open1;
		c2      = close_run(start1, len1, pok1, pstart1, cfg);
		pok2    = close2 ? c2.ok : pok1;
		pstart2 = close2 ? c2.start : pstart1;

		f1 = close1 && c1.res.line_found;
		f2 = close2 && c2.res.line_found;

		push = '0;
		if (f1 && f2) begin
			push.n            = OQ_CNT_W'(2);
			push.res0         = c1.res;
			push.res1         = c2.res;
			push.res1.row_end = 1'b1;
		end else if (f1) begin
			push.n            = OQ_CNT_W'(1);
			push.res0         = c1.res;
			push.res0.row_end = last;
		end else if (f2) begin
			push.n            = OQ_CNT_W'(1);
			push.res0         = c2.res;
			push.res0.row_end = 1'b1;
		end else if (last) begin
			push.n            = OQ_CNT_W'(1);
			push.res0.row_end = 1'b1;
		end
		if (!accept) begin
			push.n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0]     <= '0;
			hist_q[1]     <= '0;
			pos_q         <= '0;
			run_open_q    <= 1'b0;
			run_pos_q     <= 1'b0;
			run_start_q   <= '0;
			run_len_q     <= '0;
			prior_ok_q    <= 1'b0;
			prior_start_q <= '0;
		end else if (accept) begin
			hist_q[1] <= hist_q[0];
			hist_q[0] <= pixel;
			if (last) begin
				// wrap to a fresh row
				pos_q         <= '0;
				run_open_q    <= 1'b0;
				run_pos_q     <= 1'b0;
				run_start_q   <= '0;
				run_len_q     <= '0;
				prior_ok_q    <= 1'b0;
				prior_start_q <= '0;
			end else begin
				pos_q         <= pos + POS_W'(1);
				run_open_q    <= open1;
				run_pos_q     <= rpos1;
				run_start_q   <= start1;
				run_len_q     <= len1;
				prior_ok_q    <= pok2;
				prior_start_q <= pstart2;
			end
		end
	end

endmodule

// ----- src/sled_outq.sv -----
// Three-entry result queue that takes up to two items per cycle and drives the output.
module sled_outq import sled_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output result_t head,
	output logic    head_valid,
	output logic    room
);

	result_t             q     [OQ_DEPTH];
	result_t             nq    [OQ_DEPTH];
	logic [OQ_CNT_W-1:0] cnt_q;
	logic [OQ_CNT_W-1:0] base;

	assign head       = q[0];
	assign head_valid = cnt_q != '0;
	// keep space for the two items one pixel can produce
	assign room       = cnt_q <= OQ_CNT_W'(1);

	always_comb begin
		for (int i = 0; i < OQ_DEPTH; i++) begin
			nq[i] = q[i];
		end
		base = cnt_q;
		if (pop) begin
			for (int i = 0; i < OQ_DEPTH - 1; i++) begin
				nq[i] = q[i + 1];
			end
			base = cnt_q - OQ_CNT_W'(1);
		end
		if (push.n != '0) begin
			nq[base] = push.res0;
		end
		if (push.n == OQ_CNT_W'(2)) begin
			nq[base + OQ_CNT_W'(1)] = push.res1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OQ_DEPTH; i++) begin
			q[i] <= nq[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + push.n;
		end
	end

endmodule

// ----- src/scanline_edge_and_line_detector.sv -----
// Top level of the scanline edge and line detector.
//
// in_ch carries one grey pixel per item plus a row_start flag; a row has
// ROW_PIXELS pixels and wraps by itself after the last one. out_ch carries
// result items: detected lines (center and width) and, on the last pixel of
// each row, one item flagged row_end (an empty one if no line closed there).
// A pixel produces zero, one or two items.
// Rate: one pixel per cycle while in_ch.ready is high. Each pixel is processed
// in the cycle it is accepted and its items appear on out_ch from the next cycle on.
// A pixel that yields two items holds in_ch.ready low even while out_ch is ready,
// since only one item leaves per cycle.
// The output queue holds three items; in_ch.ready drops while two or more
// items wait, so a stalled receiver stops the input with at most three items
// waiting and no item is lost.
// Reset (arst_n low) loads the default thresholds and bounds, clears the
// row state and the position, and empties the output queue.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while the block is idle.
module scanline_edge_and_line_detector import sled_pkg::*; #(
	parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sled_in_if.sink               in_ch,
	sled_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	push_t   push;
	result_t head;
	logic    head_valid, room, accept, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grad_threshold <= GRAD_THR_RST;
			cfg_q.min_edge_width <= MIN_EDGE_RST;
			cfg_q.max_edge_width <= MAX_EDGE_RST;
			cfg_q.min_line_width <= MIN_LINE_RST;
			cfg_q.max_line_width <= MAX_LINE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRAD_THR: cfg_q.grad_threshold <= cfg_data[THR_W-1:0];
				CFG_MIN_EDGE: cfg_q.min_edge_width <= cfg_data[WID_W-1:0];
				CFG_MAX_EDGE: cfg_q.max_edge_width <= cfg_data[WID_W-1:0];
				CFG_MIN_LINE: cfg_q.min_line_width <= cfg_data[WID_W-1:0];
				CFG_MAX_LINE: cfg_q.max_line_width <= cfg_data[WID_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && room;
	assign pop         = head_valid && out_ch.ready;

	sled_core #(
		.ROW_PIXELS(ROW_PIXELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.pixel     (in_ch.pixel),
		.row_start (in_ch.row_start),
		.push      (push)
	);

	sled_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room       (room)
	);

	assign out_ch.valid       = head_valid;
	assign out_ch.line_found  = head.line_found;
	assign out_ch.line_center = head.line_center;
	assign out_ch.line_width  = head.line_width;
	assign out_ch.row_end     = head.row_end;

endmodule

// ----- src/sled_checker.sv -----
// Port-level assertions for the scanline edge and line detector, with its bind.
module sled_checker import sled_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             line_found,
	input logic [WID_W-1:0] line_center,
	input logic [WID_W-1:0] line_width,
	input logic             row_end
);

	// an item without a line only marks the row end
	a_empty_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_found |-> row_end)
		else $error("result without a line is not a row end");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_found |-> (line_center == '0) && (line_width == '0))
		else $error("result without a line carries nonzero fields");

	// input only stalls while results wait
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_found) &&
			$stable(line_center) && $stable(line_width) && $stable(row_end))
		else $error("stalled result changed");

endmodule

bind scanline_edge_and_line_detector sled_checker u_sled_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.line_found  (out_ch.line_found),
	.line_center (out_ch.line_center),
	.line_width  (out_ch.line_width),
	.row_end     (out_ch.row_end)
);

// ----- bench/sled_checker.sv -----
// Line checker: tracks pixel items and register writes, predicts result items and compares them.
module sled_line_checker import sled_pkg::*; #(
	parameter int ROW_PIXELS = ROW_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sled_in_if                    in_ch,
	sled_out_if                   out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t             cfg;
	logic [PIX_W-1:0] prev_pix [2];
	logic [POS_W-1:0] col;
	logic             run_open;
	logic             run_pos_grad;
	logic [POS_W-1:0] run_begin;
	logic [WID_W-1:0] run_len;
	logic             edge_held;
	logic [POS_W-1:0] held_begin;
	result_t          pending_lines [$];
	result_t          step_lines [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic void clear_row();
		run_open     = 1'b0;
		run_pos_grad = 1'b0;
		run_begin    = '0;
		run_len      = '0;
		edge_held    = 1'b0;
		held_begin   = '0;
	endfunction

	// Close the open run; pair it with the held edge when its width is in bounds.
	function automatic void close_edge();
		logic [SPAN_W-1:0] span;
		result_t           line;
		run_open = 1'b0;
		if (run_len < cfg.min_edge_width || run_len > cfg.max_edge_width) begin
			edge_held = 1'b0;
		end else begin
			if (edge_held) begin
				span = SPAN_W'(run_begin) + SPAN_W'(run_len) - SPAN_W'(held_begin);
				if (span >= SPAN_W'(cfg.min_line_width) &&
						span <= SPAN_W'(cfg.max_line_width)) begin
					line.line_found  = 1'b1;
					line.line_center = WID_W'(SPAN_W'(held_begin) + span / 2);
					line.line_width  = span[WID_W-1:0];
					line.row_end     = 1'b0;
					step_lines.push_back(line);
				end
			end
			edge_held  = 1'b1;
			held_begin = run_begin;
		end
		run_len = '0;
	endfunction

	function automatic void predict_pixel(input logic [PIX_W-1:0] pix, input logic rs);
		logic [POS_W-1:0] p;
		int               grad;
		int               thr;
		logic             pos_grad;
		result_t          last;
		step_lines.delete();
		if (rs) begin
			col = '0;
			clear_row();
		end
		p = col;
		if (p >= 2) begin
			grad = 2 * int'(prev_pix[1]) - 2 * int'(pix);
			thr  = int'(cfg.grad_threshold);
			if (grad < -thr || grad > thr) begin
				pos_grad = grad > 0;
				// a sign flip ends the old run and opens a new one on this sample
				if (run_open && run_pos_grad != pos_grad)
					close_edge();
				if (run_open) begin
					if (run_len != RUN_LEN_MAX)
						run_len++;
				end else begin
					run_open     = 1'b1;
					run_pos_grad = pos_grad;
					run_begin    = p - POS_W'(2);
					run_len      = WID_W'(1);
				end
			end else if (run_open) begin
				close_edge();
			end
		end
		prev_pix[1] = prev_pix[0];
		prev_pix[0] = pix;
		if (int'(p) >= ROW_PIXELS - 1) begin
			if (run_open)
				close_edge();
			if (step_lines.size() == 0) begin
				last         = '0;
				last.row_end = 1'b1;
				step_lines.push_back(last);
			end else begin
				last         = step_lines[step_lines.size() - 1];
				last.row_end = 1'b1;
				step_lines[step_lines.size() - 1] = last;
			end
			col = '0;
			clear_row();
		end else begin
			col = p + POS_W'(1);
		end
		foreach (step_lines[i])
			pending_lines.push_back(step_lines[i]);
	endfunction

	task automatic check_result();
		result_t want;
		if (pending_lines.size() == 0) begin
			report_mismatch("result item with nothing expected, line_width",
				int'(out_ch.line_width), 0);
		end else begin
			want = pending_lines.pop_front();
			if (out_ch.line_found !== want.line_found)
				report_mismatch("line_found", int'(out_ch.line_found), int'(want.line_found));
			if (out_ch.line_center !== want.line_center)
				report_mismatch("line_center", int'(out_ch.line_center),
					int'(want.line_center));
			if (out_ch.line_width !== want.line_width)
				report_mismatch("line_width", int'(out_ch.line_width), int'(want.line_width));
			if (out_ch.row_end !== want.row_end)
				report_mismatch("row_end", int'(out_ch.row_end), int'(want.row_end));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{grad_threshold: GRAD_THR_RST, min_edge_width: MIN_EDGE_RST,
				max_edge_width: MAX_EDGE_RST, min_line_width: MIN_LINE_RST,
				max_line_width: MAX_LINE_RST};
			prev_pix[0] = '0;
			prev_pix[1] = '0;
			col         = '0;
			clear_row();
			pending_lines.delete();
			mismatches  = 0;
			awaiting   <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			// a pixel taken at this edge still sees the old registers
			if (in_ch.valid && in_ch.ready)
				predict_pixel(in_ch.pixel, in_ch.row_start);
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GRAD_THR: cfg.grad_threshold = cfg_data[THR_W-1:0];
					CFG_MIN_EDGE: cfg.min_edge_width = cfg_data[WID_W-1:0];
					CFG_MAX_EDGE: cfg.max_edge_width = cfg_data[WID_W-1:0];
					CFG_MIN_LINE: cfg.min_line_width = cfg_data[WID_W-1:0];
					CFG_MAX_LINE: cfg.max_line_width = cfg_data[WID_W-1:0];
					default: ;
				endcase
			end
			awaiting <= pending_lines.size();
		end
	end

endmodule

// ----- bench/scanline_edge_and_line_detector_test.sv -----
// Testbench top: clock, reset, pixel rows, result stalls, register phases and the verdict.
module scanline_edge_and_line_detector_test import sled_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_LEN      = ROW_PIXELS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int PHASES       = 7;
	localparam int DIRECTED_LEN = 24;

	// row start on the first pixel and again in mid row, extremes and sign flips between
	localparam logic [PIX_W-1:0] DIRECTED_PIX [DIRECTED_LEN] = '{
		8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd0, 8'd0, 8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
	localparam logic [DIRECTED_LEN-1:0] DIRECTED_START = 24'b0000_1000_0000_0000_0000_0001;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    awaiting;
	int                    cycle_count = 0;
	bit                    calm = 1'b0;

	sled_in_if  pix_ch ();
	sled_out_if line_ch ();

	scanline_edge_and_line_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (pix_ch),
		.out_ch    (line_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sled_line_checker line_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (pix_ch),
		.out_ch     (line_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 31);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic rs);
		if (idle_now()) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while (idle_now());
		end
		pix_ch.valid     <= 1'b1;
		pix_ch.pixel     <= pix;
		pix_ch.row_start <= rs;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// Drop valid and wait until every expected item has come out.
	task automatic settle();
		int waited;
		waited = 0;
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic poke_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_config(input int thr, input int min_edge, input int max_edge,
			input int min_line, input int max_line);
		poke_reg(CFG_GRAD_THR, CFG_DATA_W'(thr));
		poke_reg(CFG_MIN_EDGE, CFG_DATA_W'(min_edge));
		poke_reg(CFG_MAX_EDGE, CFG_DATA_W'(max_edge));
		poke_reg(CFG_MIN_LINE, CFG_DATA_W'(min_line));
		poke_reg(CFG_MAX_LINE, CFG_DATA_W'(max_line));
		cfg_we <= 1'b0;
	endtask

	// One camera row: a noisy background with dark or bright bars, ramps on their sides.
	task automatic send_row();
		int               level [ROW_LEN];
		int               base;
		int               noise;
		int               wide;
		int               ramp;
		int               bar_lvl;
		int               at;
		int               cut;
		logic             first_start;
		logic [PIX_W-1:0] pix;
		base  = $urandom_range(255, 90);
		noise = $urandom_range(6, 0);
		for (int i = 0; i < ROW_LEN; i++)
			level[i] = base + int'($urandom_range(2 * noise, 0)) - noise;
		repeat ($urandom_range(8, 1)) begin
			wide    = $urandom_range(20, 1);
			ramp    = $urandom_range(3, 0);
			bar_lvl = ($urandom_range(3) == 0) ? int'($urandom_range(255, 200))
				: int'($urandom_range(90, 0));
			at      = ($urandom_range(3) == 0) ? ROW_LEN - wide - 2 * ramp
				: int'($urandom_range(ROW_LEN - 1, 0));
			for (int k = 0; k < wide + 2 * ramp && at + k < ROW_LEN; k++) begin
				if (k < ramp)
					level[at + k] = base + (bar_lvl - base) * (k + 1) / (ramp + 1);
				else if (k >= ramp + wide)
					level[at + k] = bar_lvl +
						(base - bar_lvl) * (k - ramp - wide + 1) / (ramp + 1);
				else
					level[at + k] = bar_lvl;
			end
		end
		// some rows are plain noise
		if ($urandom_range(5) == 0)
			foreach (level[i]) level[i] = $urandom_range(255, 0);
		first_start = 1'($urandom_range(1));
		cut = ($urandom_range(7) == 0) ? int'($urandom_range(ROW_LEN - 1, 1)) : -1;
		for (int i = 0; i < ROW_LEN; i++) begin
			pix = PIX_W'(level[i] < 0 ? 0 : (level[i] > 255 ? 255 : level[i]));
			send_pixel(pix, (i == 0 && first_start) || i == cut);
		end
	endtask

	initial begin
		line_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			line_ch.ready <= !idle_now();
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		pix_ch.valid     <= 1'b0;
		pix_ch.pixel     <= '0;
		pix_ch.row_start <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_GRAD_THR;
		cfg_data         <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_LEN; i++)
			send_pixel(DIRECTED_PIX[i], DIRECTED_START[i]);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;
				1: write_config(0, 0, 1023, 0, 1023);
				2: write_config(510, $urandom_range(2, 0), $urandom_range(10, 2),
					$urandom_range(8, 0), $urandom_range(60, 10));
				// minimum above maximum: no edge passes
				3: write_config($urandom_range(100, 8), 1023, $urandom_range(10, 2), 0, 1023);
				4: write_config($urandom_range(100, 8), 0, 1023, $urandom_range(1023, 1), 0);
				default: write_config($urandom_range(100, 8), $urandom_range(2, 0),
					$urandom_range(10, 2), $urandom_range(8, 0), $urandom_range(60, 10));
			endcase
			calm <= (phase == 5);
			send_row();
			settle();
		end

		if (mismatches == 0 && awaiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
